FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the transmitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PILT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pilt assertion failed");
`define PILT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pilt assertion failed");
`else
`define PILT_ASSERT(label, clk, rstn, prop)
`define PILT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/pilt_pkg.sv
// Types, codes and reset constants of the pulse interval light transmitter.
package pilt_pkg;

    localparam int MSG_BYTES_DEFAULT = 256;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] CFG_MESSAGE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_ONE_INTERVAL   = 2'd1;
    localparam logic [1:0] CFG_ZERO_INTERVAL  = 2'd2;
    localparam logic [1:0] CFG_PREAMBLE_ONES  = 2'd3;

    localparam logic [8:0]  MESSAGE_LENGTH_RST = 9'd11;
    localparam logic [15:0] ONE_INTERVAL_RST   = 16'd130;
    localparam logic [15:0] ZERO_INTERVAL_RST  = 16'd60;
    localparam logic [4:0]  PREAMBLE_ONES_RST  = 5'd12;
    localparam logic [8:0]  MAX_LENGTH         = 9'd256;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_address;
        logic [7:0] byte_value;
    } pilt_in_t;

    typedef struct packed {
        logic line_level;
        logic symbol_start;
        logic symbol_bit;
        logic frame_wrap;
    } pilt_out_t;

endpackage

FILE: hw/rtl/pulse_interval_light_transmitter.sv
// Top level of the pulse interval light transmitter.
//
// Input channel s_*: one word per operation (tick, load message byte, restart
// frame). Result channel m_*: one word for every accepted input word, carrying
// the line level after the operation and the symbol start, symbol bit and
// frame wrap flags of that tick.
// m_valid rises in the cycle after acceptance. One word is taken per cycle
// while the receiver keeps up: the frame state sits in registers and the
// message bytes in one RAM whose read port follows the next byte position
// every cycle, with a forward path for a load to that same byte.
// Configuration writes on cfg_* are to be made by the user while idle; the
// block does not enforce this. Reset clears the frame position, the light
// phase, the countdown and the configuration to defaults; the message RAM
// holds no reset value and is not cleared. When the receiver stalls, the
// result holds in its output register and s_ready drops until it is taken.
`include "assert_macros.svh"

module pulse_interval_light_transmitter import pilt_pkg::*; #(
    parameter int MSG_BYTES = MSG_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pilt_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pilt_out_t   m_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    logic [8:0]  msg_len_reg;
    logic [15:0] one_int_reg;
    logic [15:0] zero_int_reg;
    logic [4:0]  pre_ones_reg;

    logic [8:0]  pos_reg, pos_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [4:0]  pre_left_reg, pre_left_next;
    logic        phase_reg, phase_next;
    logic [15:0] cd_reg, cd_next;

    logic        fwd_valid_reg;
    logic [7:0]  fwd_data_reg;
    logic        m_valid_reg;
    pilt_out_t   m_data_reg, m_data_next;

    logic        accept;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]  rd_data;
    logic [7:0]  cur_byte;
    logic [8:0]  len;
    logic        in_range;
    logic        bit_val;
    logic [15:0] interval;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign wr_en   = aresetn && accept && (s_data.opcode == OP_LOAD)
                     && (32'(s_data.byte_address) < MSG_BYTES);
    assign wr_addr = AW'(s_data.byte_address);
    assign rd_addr = aresetn ? AW'(pos_next) : '0;

    pilt_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_msg_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.byte_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_byte = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign len      = (msg_len_reg > MAX_LENGTH) ? MAX_LENGTH : msg_len_reg;
    assign in_range = (pos_reg < len) && (32'(pos_reg) < MSG_BYTES);

    always_comb begin
        pos_next      = pos_reg;
        bit_pos_next  = bit_pos_reg;
        pre_left_next = pre_left_reg;
        phase_next    = phase_reg;
        cd_next       = cd_reg;
        bit_val       = 1'b0;
        interval      = zero_int_reg;
        m_data_next   = '0;
        if (accept) begin
            case (s_data.opcode)
                OP_TICK: begin
                    if (cd_reg == 16'd0) begin
                        phase_next               = !phase_reg;
                        m_data_next.symbol_start = 1'b1;
                        if (pre_left_reg != 5'd0) begin
                            bit_val       = 1'b1;
                            pre_left_next = pre_left_reg - 5'd1;
                        end else begin
                            bit_val = in_range && cur_byte[bit_pos_reg];
                            if (bit_pos_reg == 3'd0) begin
                                if ({1'b0, pos_reg} >= ({1'b0, len} + 10'd1)) begin
                                    pos_next               = '0;
                                    bit_pos_next           = 3'd7;
                                    pre_left_next          = pre_ones_reg;
                                    m_data_next.frame_wrap = 1'b1;
                                end else begin
                                    pos_next     = pos_reg + 9'd1;
                                    bit_pos_next = 3'd7;
                                end
                            end else begin
                                bit_pos_next = bit_pos_reg - 3'd1;
                            end
                        end
                        interval = bit_val ? one_int_reg : zero_int_reg;
                        cd_next  = (interval == 16'd0) ? 16'd0 : interval - 16'd1;
                    end else begin
                        cd_next = cd_reg - 16'd1;
                    end
                end
                OP_RESTART: begin
                    pos_next      = '0;
                    bit_pos_next  = 3'd7;
                    pre_left_next = pre_ones_reg;
                end
                default: begin
                end
            endcase
            m_data_next.symbol_bit = bit_val;
        end
        m_data_next.line_level = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_len_reg   <= MESSAGE_LENGTH_RST;
            one_int_reg   <= ONE_INTERVAL_RST;
            zero_int_reg  <= ZERO_INTERVAL_RST;
            pre_ones_reg  <= PREAMBLE_ONES_RST;
            pos_reg       <= '0;
            bit_pos_reg   <= 3'd7;
            pre_left_reg  <= PREAMBLE_ONES_RST;
            phase_reg     <= 1'b0;
            cd_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_MESSAGE_LENGTH: msg_len_reg  <= cfg_data[8:0];
                    CFG_ONE_INTERVAL:   one_int_reg  <= cfg_data;
                    CFG_ZERO_INTERVAL:  zero_int_reg <= cfg_data;
                    CFG_PREAMBLE_ONES:  pre_ones_reg <= cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            pos_reg       <= pos_next;
            bit_pos_reg   <= bit_pos_next;
            pre_left_reg  <= pre_left_next;
            phase_reg     <= phase_next;
            cd_reg        <= cd_next;
            fwd_valid_reg <= wr_en && (wr_addr == rd_addr);
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= s_data.byte_value;
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    `PILT_ASSERT_NEXT(a_idle_op_holds, aclk, aresetn,
        accept && s_data.opcode != OP_TICK, $stable(cd_reg) && $stable(phase_reg))
    `PILT_ASSERT_NEXT(a_toggle_on_zero, aclk, aresetn,
        accept && s_data.opcode == OP_TICK && cd_reg == 16'd0,
        phase_reg != $past(phase_reg))
    `PILT_ASSERT(a_bits_after_preamble, aclk, aresetn,
        bit_pos_reg != 3'd7 |-> pre_left_reg == 5'd0)
    `PILT_ASSERT(a_fwd_from_write, aclk, aresetn,
        fwd_valid_reg |-> $past(wr_en))
    `PILT_ASSERT_NEXT(a_result_follows, aclk, aresetn,
        accept, m_valid_reg && m_data_reg.line_level == phase_reg)

endmodule

FILE: hw/rtl/pilt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pilt_ram import pilt_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = MSG_BYTES_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
